/* hdl/qec_pkg.sv */
// Package for the quadrature encoder counter unit.
// Holds field widths, command and register codes, and the item and snapshot types.
// No dependencies.
package qec_pkg;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int PRELOAD_W  = 24;
  localparam int COUNT_W    = 32;
  localparam int PINS_W     = 2;
  localparam int ANGLE_W    = 48;
  localparam int FACTOR_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Product shifts that bring Q8.24 and Q4.28 products to 16 fraction bits
  localparam int DEG_SHIFT = 8;
  localparam int RAD_SHIFT = 12;

  // Commands
  localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INDEX   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PRELOAD = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X4_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEG_PER_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAD_PER_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_RAD = 2'd3;

  // Pin codes, A in bit 1 and B in bit 0
  localparam logic [PINS_W-1:0] PINS_00 = 2'b00;
  localparam logic [PINS_W-1:0] PINS_01 = 2'b01;
  localparam logic [PINS_W-1:0] PINS_10 = 2'b10;
  localparam logic [PINS_W-1:0] PINS_11 = 2'b11;

  // One accepted input item
  typedef struct packed {
    logic [CMD_W-1:0]            command;
    logic                        chan_a;
    logic                        chan_b;
    logic signed [PRELOAD_W-1:0] preload_rad;
  } qec_item_t;

  // Counter values after one item
  typedef struct packed {
    logic signed [COUNT_W-1:0] position_count;
    logic signed [COUNT_W-1:0] absolute_count;
    logic [COUNT_W-1:0]        revolutions;
    logic [PINS_W-1:0]         quad_state;
  } qec_snap_t;

  // Load enables of the two scaling stages
  typedef struct packed {
    logic prod;
    logic sat;
  } qec_stage_en_t;

endpackage

/* hdl/qec_in_if.sv */
// Input channel of the quadrature encoder counter: valid, ready and one command item.
// Depends on qec_pkg.
interface qec_in_if;
  import qec_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [CMD_W-1:0]            command;
  logic                        chan_a;
  logic                        chan_b;
  logic signed [PRELOAD_W-1:0] preload_rad;

  modport source (output valid, command, chan_a, chan_b, preload_rad, input ready);
  modport sink (input valid, command, chan_a, chan_b, preload_rad, output ready);
endinterface

/* hdl/qec_out_if.sv */
// Output channel of the quadrature encoder counter: valid, ready and one result item.
// Depends on qec_pkg.
interface qec_out_if;
  import qec_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COUNT_W-1:0] position_count;
  logic signed [COUNT_W-1:0] absolute_count;
  logic [COUNT_W-1:0]        revolutions;
  logic [PINS_W-1:0]         quad_state;
  logic signed [ANGLE_W-1:0] angle_deg;
  logic signed [ANGLE_W-1:0] angle_rad;

  modport source (output valid, position_count, absolute_count, revolutions, quad_state,
                  angle_deg, angle_rad, input ready);
  modport sink (input valid, position_count, absolute_count, revolutions, quad_state,
                angle_deg, angle_rad, output ready);
endinterface

/* hdl/quadrature_encoder_counter_unit.sv */
// Top level of the quadrature encoder counter: input register, counter update,
// angle scaling and output register. Depends on qec_pkg, qec_in_if, qec_out_if,
// qec_decode and qec_scale.
//
// The unit takes one command item per clock (pin sample, index pulse, clear or
// preload from an angle) and returns one result item for each, in order: the
// position, absolute and revolution counts after the item, the stored pin state,
// and the position in degrees and radians as saturating signed Q31.16. Items flow
// through four register stages (input, counter update, product, saturation), and a
// new item is taken every cycle while the output side keeps up; the counter update,
// with the preload multiply, is the loop that sets that rate. Configuration writes
// take effect for items accepted after the write; the user must make them while the
// unit is idle, and the unit itself does not enforce this.
module quadrature_encoder_counter_unit (
  input  logic                              clk,
  input  logic                              rst,
  qec_in_if.sink                            in_ch,
  qec_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [qec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qec_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import qec_pkg::*;

  // Configuration registers
  logic                x4_mode;
  logic [FACTOR_W-1:0] deg_per_count;
  logic [FACTOR_W-1:0] rad_per_count;
  logic [FACTOR_W-1:0] counts_per_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      x4_mode        <= 1'b1;
      deg_per_count  <= '0;
      rad_per_count  <= '0;
      counts_per_rad <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X4_MODE:        x4_mode        <= cfg_data[0];
        CFG_DEG_PER_COUNT:  deg_per_count  <= cfg_data[FACTOR_W-1:0];
        CFG_RAD_PER_COUNT:  rad_per_count  <= cfg_data[FACTOR_W-1:0];
        CFG_COUNTS_PER_RAD: counts_per_rad <= cfg_data[FACTOR_W-1:0];
        default:            x4_mode        <= x4_mode;
      endcase
    end
  end

  // Pipeline occupancy and load enables; a stage loads when empty or moving on.
  logic v_in, v_upd, v_prod, v_out;
  logic en_in, en_upd, en_prod, en_out;
  qec_stage_en_t scale_en;

  assign en_out  = !v_out || out_ch.ready;
  assign en_prod = !v_prod || en_out;
  assign en_upd  = !v_upd || en_prod;
  assign en_in   = !v_in || en_upd;
  assign in_ch.ready = en_in;
  assign scale_en.prod = en_prod;
  assign scale_en.sat  = en_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in   <= 1'b0;
      v_upd  <= 1'b0;
      v_prod <= 1'b0;
      v_out  <= 1'b0;
    end else begin
      if (en_in)   v_in   <= in_ch.valid;
      if (en_upd)  v_upd  <= v_in;
      if (en_prod) v_prod <= v_upd;
      if (en_out)  v_out  <= v_prod;
    end
  end

  // Input register
  qec_item_t item;

  always_ff @(posedge clk) begin
    if (en_in) begin
      item.command     <= in_ch.command;
      item.chan_a      <= in_ch.chan_a;
      item.chan_b      <= in_ch.chan_b;
      item.preload_rad <= in_ch.preload_rad;
    end
  end

  // Counter update
  qec_snap_t snap_upd;

  qec_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .upd            (en_upd && v_in),
    .load           (en_upd),
    .item           (item),
    .x4_mode        (x4_mode),
    .counts_per_rad (counts_per_rad),
    .snap           (snap_upd)
  );

  // Counter values ride along with the scaling stages.
  qec_snap_t snap_prod, snap_out;

  always_ff @(posedge clk) begin
    if (en_prod) snap_prod <= snap_upd;
    if (en_out)  snap_out  <= snap_prod;
  end

  // Angle scaling
  logic signed [ANGLE_W-1:0] angle_deg, angle_rad;

  qec_scale #(.SHIFT(DEG_SHIFT)) u_scale_deg (
    .clk    (clk),
    .en     (scale_en),
    .count  (snap_upd.position_count),
    .factor (deg_per_count),
    .angle  (angle_deg)
  );

  qec_scale #(.SHIFT(RAD_SHIFT)) u_scale_rad (
    .clk    (clk),
    .en     (scale_en),
    .count  (snap_upd.position_count),
    .factor (rad_per_count),
    .angle  (angle_rad)
  );

  // Result item
  assign out_ch.valid          = v_out;
  assign out_ch.position_count = snap_out.position_count;
  assign out_ch.absolute_count = snap_out.absolute_count;
  assign out_ch.revolutions    = snap_out.revolutions;
  assign out_ch.quad_state     = snap_out.quad_state;
  assign out_ch.angle_deg      = angle_deg;
  assign out_ch.angle_rad      = angle_rad;

endmodule

/* hdl/qec_decode.sv */
// Quadrature decoder and counter state: applies one command item to the counters.
// Depends on qec_pkg.
module qec_decode (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 upd,
  input  logic                                 load,
  input  qec_pkg::qec_item_t                   item,
  input  logic                                 x4_mode,
  input  logic [qec_pkg::FACTOR_W-1:0]         counts_per_rad,
  output qec_pkg::qec_snap_t                   snap
);
  import qec_pkg::*;

  logic [COUNT_W-1:0] position_reg, position_next;
  logic [COUNT_W-1:0] absolute_reg, absolute_next;
  logic [COUNT_W-1:0] revolution_reg, revolution_next;
  logic [PINS_W-1:0]  prev_pins, prev_pins_next;
  logic               primed, primed_next;

  logic [PINS_W-1:0]             cur;
  logic [PINS_W-1:0]             diff;
  logic                          preload_neg;
  logic [PRELOAD_W-1:0]          preload_mag;
  logic [PRELOAD_W+FACTOR_W-1:0] preload_prod;
  logic [COUNT_W-1:0]            preload_cnt;
  logic                          step_en;
  logic                          step_down;

  assign cur  = {item.chan_a, item.chan_b};
  assign diff = cur ^ prev_pins;

  // Preload: magnitude times counts per radian, integer part, sign restored
  assign preload_neg  = item.preload_rad[PRELOAD_W-1];
  assign preload_mag  = preload_neg ? (PRELOAD_W'(0) - item.preload_rad) : item.preload_rad;
  assign preload_prod = {{FACTOR_W{1'b0}}, preload_mag} * {{PRELOAD_W{1'b0}}, counts_per_rad};
  assign preload_cnt  = COUNT_W'(preload_prod[PRELOAD_W+FACTOR_W-1:FACTOR_W]);

  // Next state of the counters for the item in the input register
  always_comb begin
    position_next   = position_reg;
    absolute_next   = absolute_reg;
    revolution_next = revolution_reg;
    prev_pins_next  = prev_pins;
    primed_next     = primed;
    step_en         = 1'b0;
    step_down       = 1'b0;
    case (item.command)
      CMD_SAMPLE: begin
        if (!primed) begin
          // The first sample only primes the stored pins.
          prev_pins_next = cur;
          primed_next    = 1'b1;
        end else if (x4_mode) begin
          // Single-bit transitions count; double jumps are dropped.
          step_en        = (diff == PINS_01) || (diff == PINS_10);
          step_down      = prev_pins[0] ^ cur[1];
          prev_pins_next = cur;
        end else if (diff[1]) begin
          // Channel A changed: 3 and 0 swap counts up, 1 and 2 swap counts down.
          if ((prev_pins == PINS_11 && cur == PINS_00) ||
              (prev_pins == PINS_00 && cur == PINS_11)) begin
            step_en = 1'b1;
          end else if ((prev_pins == PINS_10 && cur == PINS_01) ||
                       (prev_pins == PINS_01 && cur == PINS_10)) begin
            step_en   = 1'b1;
            step_down = 1'b1;
          end
          prev_pins_next = cur;
        end
      end
      CMD_INDEX: begin
        revolution_next = revolution_reg + COUNT_W'(1);
      end
      CMD_CLEAR: begin
        position_next   = '0;
        revolution_next = '0;
      end
      CMD_PRELOAD: begin
        position_next = preload_neg ? (COUNT_W'(0) - preload_cnt) : preload_cnt;
      end
      default: begin
        position_next = position_reg;
      end
    endcase
    if (step_en) begin
      position_next = step_down ? position_reg - COUNT_W'(1) : position_reg + COUNT_W'(1);
      absolute_next = step_down ? absolute_reg - COUNT_W'(1) : absolute_reg + COUNT_W'(1);
    end
  end

  // Counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      position_reg   <= '0;
      absolute_reg   <= '0;
      revolution_reg <= '0;
      prev_pins      <= '0;
      primed         <= 1'b0;
    end else if (upd) begin
      position_reg   <= position_next;
      absolute_reg   <= absolute_next;
      revolution_reg <= revolution_next;
      prev_pins      <= prev_pins_next;
      primed         <= primed_next;
    end
  end

  // Snapshot of the counters after this item
  always_ff @(posedge clk) begin
    if (load) begin
      snap.position_count <= position_next;
      snap.absolute_count <= absolute_next;
      snap.revolutions    <= revolution_next;
      snap.quad_state     <= prev_pins_next;
    end
  end

endmodule

/* hdl/qec_scale.sv */
// Fixed-point angle scaling: signed count times unsigned factor, saturated to 48 bits.
// Two register stages: product, then truncated and saturated angle. Depends on qec_pkg.
module qec_scale #(
  parameter int SHIFT = qec_pkg::DEG_SHIFT
) (
  input  logic                                clk,
  input  qec_pkg::qec_stage_en_t              en,
  input  logic signed [qec_pkg::COUNT_W-1:0]  count,
  input  logic [qec_pkg::FACTOR_W-1:0]        factor,
  output logic signed [qec_pkg::ANGLE_W-1:0]  angle
);
  import qec_pkg::*;

  localparam int PROD_W = COUNT_W + FACTOR_W;
  localparam int Q_W    = PROD_W - SHIFT;

  logic                 neg;
  logic [COUNT_W-1:0]   mag;
  logic [PROD_W-1:0]    prod;
  logic                 prod_neg;
  logic [Q_W-1:0]       q;
  logic [ANGLE_W-1:0]   q_pos;
  logic [ANGLE_W-1:0]   q_neg;

  assign neg = count[COUNT_W-1];
  assign mag = neg ? (COUNT_W'(0) - count) : count;

  // Stage one: magnitude product
  always_ff @(posedge clk) begin
    if (en.prod) begin
      prod     <= {{FACTOR_W{1'b0}}, mag} * {{COUNT_W{1'b0}}, factor};
      prod_neg <= neg;
    end
  end

  // Truncate to 16 fraction bits, then clamp the magnitude to the signed range.
  assign q = prod[PROD_W-1:SHIFT];

  always_comb begin
    if (|q[Q_W-1:ANGLE_W-1]) begin
      q_pos = {1'b0, {(ANGLE_W-1){1'b1}}};
    end else begin
      q_pos = q[ANGLE_W-1:0];
    end
    if ((|q[Q_W-1:ANGLE_W]) || (q[ANGLE_W-1] && (|q[ANGLE_W-2:0]))) begin
      q_neg = {1'b1, {(ANGLE_W-1){1'b0}}};
    end else begin
      q_neg = q[ANGLE_W-1:0];
    end
  end

  // Stage two: signed saturated angle
  always_ff @(posedge clk) begin
    if (en.sat) begin
      angle <= prod_neg ? (ANGLE_W'(0) - q_neg) : q_pos;
    end
  end

endmodule
